/* hw/rtl/vci16_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vci16_pkg: shared types and constants for the valid convolution block
// Field widths, item codes and the control/status bundles of the mac unit.
// ----------------------------------------------------------------------------
package vci16_pkg;

    // default depth of the tap store and sample window
    localparam int MAX_TAPS_DEFAULT = 32;

    // field widths
    localparam int VALUE_W     = 16;
    localparam int SUM_W       = 32;
    localparam int TAP_IDX_W   = 5;
    localparam int TAP_CNT_W   = 6;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;

    // reset value of the tap count register
    localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET = 6'd2;
    localparam logic [TAP_CNT_W-1:0] TAP_COUNT_MIN   = 6'd2;

    // item kinds carried on tuser
    localparam logic MODE_TAP    = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // sequencer to mac unit
    typedef struct packed {
        logic clear;    // zero the accumulator before a new sum
        logic in_vld;   // operands on the inputs are valid this cycle
    } mac_ctrl_t;

    // mac unit to sequencer
    typedef struct packed {
        logic busy;     // a product is still in flight
    } mac_stat_t;

endpackage

/* hw/rtl/vci16_tap_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vci16_tap_ram: coefficient store
// One write port for tap loads, one registered read port for the tap walk.
// ----------------------------------------------------------------------------
module vci16_tap_ram #(
    parameter int MAX_TAPS = vci16_pkg::MAX_TAPS_DEFAULT,
    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [vci16_pkg::VALUE_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [vci16_pkg::VALUE_W-1:0] rd_data
);

    logic [vci16_pkg::VALUE_W-1:0] mem [MAX_TAPS];
    logic [vci16_pkg::VALUE_W-1:0] rd_data_reg;

    // tap write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/vci16_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vci16_window: sample window as a circular buffer
// A push writes the newest sample; reads then walk from newest to oldest.
// ----------------------------------------------------------------------------
module vci16_window #(
    parameter int MAX_TAPS = vci16_pkg::MAX_TAPS_DEFAULT,
    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  logic [vci16_pkg::VALUE_W-1:0] push_data,
    input  logic                          rd_en,
    output logic [vci16_pkg::VALUE_W-1:0] rd_data
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

    logic [vci16_pkg::VALUE_W-1:0] mem [MAX_TAPS];
    logic [vci16_pkg::VALUE_W-1:0] rd_data_reg;
    logic [AW-1:0]                 wptr_reg, wptr_next;
    logic [AW-1:0]                 rptr_reg, rptr_next;

    // next write slot, wrapping at the depth
    always_comb begin
        wptr_next = (wptr_reg == LAST_ADDR) ? '0 : wptr_reg + AW'(1);
    end

    // read pointer: starts at the newest sample, steps back toward older ones
    always_comb begin
        rptr_next = rptr_reg;
        if (push) begin
            rptr_next = wptr_next;
        end else if (rd_en) begin
            rptr_next = (rptr_reg == '0) ? LAST_ADDR : rptr_reg - AW'(1);
        end
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_next;
            end
            rptr_reg <= rptr_next;
        end
    end

    // sample write
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_next] <= push_data;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rptr_reg];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/vci16_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vci16_mac: shared multiply-accumulate unit
// Registered 16x16 signed product, then a wrapping 32-bit accumulate.
// ----------------------------------------------------------------------------
module vci16_mac (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  vci16_pkg::mac_ctrl_t          ctrl,
    input  logic [vci16_pkg::VALUE_W-1:0] op_a,
    input  logic [vci16_pkg::VALUE_W-1:0] op_b,
    output vci16_pkg::mac_stat_t          stat,
    output logic [vci16_pkg::SUM_W-1:0]   acc
);

    logic signed [vci16_pkg::SUM_W-1:0] prod_full;
    logic [vci16_pkg::SUM_W-1:0]        prod_reg;
    logic                               pvld_reg;
    logic [vci16_pkg::SUM_W-1:0]        acc_reg;

    // full-width signed product, operands sign-extended to the sum width
    assign prod_full = $signed(op_a) * $signed(op_b);

    // product stage
    always_ff @(posedge aclk) begin
        if (ctrl.in_vld) begin
            prod_reg <= prod_full;
        end
    end

    // product valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvld_reg <= 1'b0;
        end else begin
            pvld_reg <= ctrl.in_vld;
        end
    end

    // accumulate, wrapping modulo 2^32
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (pvld_reg) begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign stat.busy = pvld_reg;
    assign acc       = acc_reg;

endmodule

/* hw/rtl/valid_convolution_i16_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valid_convolution_i16_top: streaming valid-mode convolution, 16-bit in
// Tap items load the coefficient store, sample items shift the window and,
// once the window holds tap_count samples of the vector, give one sum.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  s_       | in  | s_tvalid/s_tready  | tdata: tap_index, value; tuser: mode;
//           |     |                    | tlast: last_in
//  m_       | out | m_tvalid/m_tready  | tdata: sum_out; tlast: last_out
//  cfg_     | in  | cfg_wr_en          | cfg_wr_data: tap_count
//
//  Input is taken only while the sequencer is idle. A sample that gives a
//  result is worked through one multiply-accumulate per tap, with the tap
//  and window read registers and the product register in between.
//  Reset is synchronous, active low; the tap store is not cleared.
//  A waiting result sits in the output register; the next item is taken
//  meanwhile and holds in the sequencer only when its own sum is done.
// ----------------------------------------------------------------------------
module valid_convolution_i16_top #(
    parameter int MAX_TAPS = vci16_pkg::MAX_TAPS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [vci16_pkg::S_TDATA_W-1:0] s_tdata,   // [4:0] tap_index, [20:5] value
    input  logic                            s_tuser,   // [0] mode
    input  logic                            s_tlast,
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [vci16_pkg::M_TDATA_W-1:0] m_tdata,   // [31:0] sum_out
    output logic                            m_tlast,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [vci16_pkg::TAP_CNT_W-1:0] cfg_wr_data
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW = vci16_pkg::TAP_CNT_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]                      state_reg, state_next;
    logic [CW-1:0]                   tap_count_reg;
    logic [CW-1:0]                   fill_reg, fill_next;
    logic [CW-1:0]                   taps_reg, taps_next;
    logic [CW-1:0]                   idx_reg, idx_next;
    logic                            last_reg, last_next;
    logic                            dvld_reg;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [vci16_pkg::SUM_W-1:0]     m_tdata_reg;
    logic                            m_tlast_reg;

    logic                            accept;
    logic                            is_sample;
    logic [vci16_pkg::TAP_IDX_W-1:0] in_tap_index;
    logic [vci16_pkg::VALUE_W-1:0]   in_value;
    logic [CW-1:0]                   taps_use;
    logic [CW-1:0]                   fill_inc;
    logic                            start;
    logic                            tap_wr;
    logic                            rd_en;
    logic                            sum_done;
    logic                            out_load;

    logic [vci16_pkg::VALUE_W-1:0]   tap_data;
    logic [vci16_pkg::VALUE_W-1:0]   win_data;
    vci16_pkg::mac_ctrl_t            mac_ctrl;
    vci16_pkg::mac_stat_t            mac_stat;
    logic [vci16_pkg::SUM_W-1:0]     mac_acc;

    // input unpacking and handshake
    assign in_tap_index = s_tdata[vci16_pkg::TAP_IDX_W-1:0];
    assign in_value     = s_tdata[vci16_pkg::TAP_IDX_W +: vci16_pkg::VALUE_W];
    assign s_tready     = (state_reg == ST_IDLE);
    assign accept       = s_tvalid && s_tready;
    assign is_sample    = (s_tuser == vci16_pkg::MODE_SAMPLE);

    // tap count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= vci16_pkg::TAP_COUNT_RESET;
        end else if (cfg_wr_en) begin
            tap_count_reg <= cfg_wr_data;
        end
    end

    // taps in use, clamped to the legal range
    always_comb begin
        taps_use = tap_count_reg;
        if (tap_count_reg < vci16_pkg::TAP_COUNT_MIN) begin
            taps_use = vci16_pkg::TAP_COUNT_MIN;
        end else if (32'(tap_count_reg) > MAX_TAPS) begin
            taps_use = CW'(MAX_TAPS);
        end
    end

    // window fill, saturating at the taps in use
    assign fill_inc = (fill_reg >= taps_use) ? taps_use : fill_reg + CW'(1);
    assign start    = accept && is_sample && (fill_inc == taps_use);
    assign tap_wr   = accept && !is_sample && (32'(in_tap_index) < MAX_TAPS);
    assign rd_en    = (state_reg == ST_RUN);
    assign sum_done = !dvld_reg && !mac_stat.busy;
    assign out_load = (state_reg == ST_DRAIN) && sum_done
                      && (!m_tvalid_reg || m_tready);

    // sequencer
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        taps_next  = taps_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && is_sample) begin
                    fill_next = s_tlast ? '0 : fill_inc;
                    if (start) begin
                        taps_next  = taps_use;
                        last_next  = s_tlast;
                        idx_next   = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                idx_next = idx_reg + CW'(1);
                if (idx_reg == taps_reg - CW'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            dvld_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            dvld_reg  <= rd_en;
        end
    end

    // per-item working registers
    always_ff @(posedge aclk) begin
        taps_reg <= taps_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
    end

    // coefficient store
    vci16_tap_ram #(
        .MAX_TAPS (MAX_TAPS)
    ) u_tap_ram (
        .aclk    (aclk),
        .wr_en   (tap_wr),
        .wr_addr (AW'(in_tap_index)),
        .wr_data (in_value),
        .rd_en   (rd_en),
        .rd_addr (AW'(idx_reg)),
        .rd_data (tap_data)
    );

    // sample window
    vci16_window #(
        .MAX_TAPS (MAX_TAPS)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && is_sample),
        .push_data (in_value),
        .rd_en     (rd_en),
        .rd_data   (win_data)
    );

    // shared multiply-accumulate
    assign mac_ctrl.clear  = start;
    assign mac_ctrl.in_vld = dvld_reg;

    vci16_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .op_a    (tap_data),
        .op_b    (win_data),
        .stat    (mac_stat),
        .acc     (mac_acc)
    );

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= mac_acc;
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
